// ----- rtl/xpe_pkg.sv -----
// Package for the XOR parity erasure encoder: sizes, register codes and the
// queue entry type shared by the front, queue, back and top level.
// No dependencies.
package xpe_pkg;

  // Stripe and word sizing
  localparam int DATA_MAX   = 32;
  localparam int PARITY_MAX = 6;
  localparam int WORD_BITS  = 64;

  // Fixed port geometry
  localparam int NUM_OUT    = 6;
  localparam int NUM_MASKS  = 6;
  localparam int OUT_BITS   = 64;
  localparam int IDX_BITS   = 5;
  localparam int DC_BITS    = 6;
  localparam int PC_BITS    = 3;
  localparam int MASK_BITS  = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // Parity lanes actually built
  localparam int PAR_LANES = (PARITY_MAX < NUM_OUT) ? PARITY_MAX : NUM_OUT;
  localparam int LANE_BITS = (PAR_LANES > 1) ? $clog2(PAR_LANES + 1) : 1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Configuration register codes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DATA_COUNT   = 3'd0,
    REG_PARITY_COUNT = 3'd1,
    REG_MASK_0       = 3'd2,
    REG_MASK_1       = 3'd3,
    REG_MASK_2       = 3'd4,
    REG_MASK_3       = 3'd5,
    REG_MASK_4       = 3'd6,
    REG_MASK_5       = 3'd7
  } cfg_reg_t;

  // One classified word on its way to the accumulators
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [PAR_LANES-1:0] member;  // lanes that XOR this word in
    logic [PAR_LANES-1:0] active;  // lanes below the parity count
    logic                 last;    // closes the stripe position
  } xpe_entry_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic valid;
  } xpe_qstat_t;

endpackage

// ----- rtl/xpe_front.sv -----
// Front end of the XOR parity encoder: holds the configuration registers,
// accepts input transactions and classifies each word into a queue entry.
// Depends on xpe_pkg.
module xpe_front import xpe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [IDX_BITS-1:0]      block_index,
  input  logic [63:0]              data_word,
  input  xpe_qstat_t               qstat,
  output logic                     push,
  output xpe_entry_t               push_entry
);

  localparam logic [DC_BITS-1:0] DATA_MAX_C  = DC_BITS'(DATA_MAX);
  localparam logic [PC_BITS-1:0] PAR_LANES_C = PC_BITS'(PAR_LANES);

  logic [DC_BITS-1:0]   data_count;
  logic [PC_BITS-1:0]   parity_count;
  logic [MASK_BITS-1:0] parity_mask [NUM_MASKS];

  logic [DC_BITS-1:0] eff_dc;
  logic [PC_BITS-1:0] eff_pc;
  logic [DC_BITS-1:0] idx_ext;
  logic               in_range;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      data_count   <= DC_BITS'(1);
      parity_count <= PC_BITS'(1);
      for (int i = 0; i < NUM_MASKS; i++) parity_mask[i] <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index) inside
        REG_DATA_COUNT:   data_count   <= cfg_wr_data[DC_BITS-1:0];
        REG_PARITY_COUNT: parity_count <= cfg_wr_data[PC_BITS-1:0];
        [REG_MASK_0:REG_MASK_5]:
          parity_mask[CFG_IDX_BITS'(cfg_index - REG_MASK_0)] <= cfg_wr_data[MASK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective counts after saturation
  assign eff_dc  = (data_count > DATA_MAX_C) ? DATA_MAX_C : data_count;
  assign eff_pc  = (parity_count > PAR_LANES_C) ? PAR_LANES_C : parity_count;
  assign idx_ext = DC_BITS'(block_index);

  // Words beyond the data count are taken and dropped
  assign in_ready = !qstat.full;
  assign in_range = idx_ext < eff_dc;
  assign push     = in_valid && in_ready && in_range;

  // Classification
  always_comb begin
    push_entry.word = data_word[WORD_BITS-1:0];
    push_entry.last = (idx_ext + DC_BITS'(1)) == eff_dc;
    for (int j = 0; j < PAR_LANES; j++) begin
      push_entry.active[j] = LANE_BITS'(j) < LANE_BITS'(eff_pc);
      push_entry.member[j] = push_entry.active[j] && parity_mask[j][block_index];
    end
  end

endmodule

// ----- rtl/xpe_queue.sv -----
// Short register queue that decouples the classifying front from the
// accumulating back of the XOR parity encoder.
// Depends on xpe_pkg.
module xpe_queue import xpe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  xpe_entry_t push_entry,
  input  logic       pop,
  output xpe_entry_t head,
  output xpe_qstat_t qstat
);

  xpe_entry_t           mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= QPTR_BITS'(wr_ptr + 1'b1);
      if (pop)  rd_ptr <= QPTR_BITS'(rd_ptr + 1'b1);
      case ({push, pop})
        2'b10:   count <= QCNT_BITS'(count + 1'b1);
        2'b01:   count <= QCNT_BITS'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

  assign head        = mem[rd_ptr];
  assign qstat.full  = count == QCNT_BITS'(QUEUE_DEPTH);
  assign qstat.valid = count != '0;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("queue empty but pointers differ");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == QCNT_BITS'($past(count) + 1'b1)))
    else $error("queue push lost");

endmodule

// ----- rtl/xpe_back.sv -----
// Back end of the XOR parity encoder: parity accumulators and the output
// register that holds a finished result transaction.
// Depends on xpe_pkg.
module xpe_back import xpe_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  xpe_entry_t          head,
  input  xpe_qstat_t          qstat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_BITS-1:0] parity_word [NUM_OUT]
);

  logic [WORD_BITS-1:0] acc      [PAR_LANES];
  logic [WORD_BITS-1:0] acc_next [PAR_LANES];
  logic [WORD_BITS-1:0] result   [PAR_LANES];

  // A closing entry waits for the output register to free up
  assign pop = qstat.valid && (!head.last || !out_valid || out_ready);

  // Per-lane XOR
  always_comb begin
    for (int j = 0; j < PAR_LANES; j++) begin
      acc_next[j] = acc[j] ^ (head.member[j] ? head.word : '0);
    end
  end

  // Accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < PAR_LANES; j++) acc[j] <= '0;
    end else if (pop) begin
      for (int j = 0; j < PAR_LANES; j++) acc[j] <= head.last ? '0 : acc_next[j];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      for (int j = 0; j < PAR_LANES; j++) begin
        result[j] <= head.active[j] ? acc_next[j] : '0;
      end
    end
  end

  // Lanes beyond the built parity count read zero
  always_comb begin
    for (int j = 0; j < NUM_OUT; j++) parity_word[j] = '0;
    for (int j = 0; j < PAR_LANES; j++) parity_word[j] = OUT_BITS'(result[j]);
  end

  // Checks
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (pop && head.last) |=> (acc[0] == '0))
    else $error("accumulator not cleared after stripe close");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(pop && head.last))
    else $error("result overwritten while held");

endmodule

// ----- rtl/xor_parity_erasure_encoder_core.sv -----
// XOR parity erasure encoder, top level: front, queue and back wired up.
// Depends on xpe_pkg, xpe_front, xpe_queue and xpe_back.
//
// Takes one data word per clock for one word position of a stripe, tagged
// with its data block index; each parity lane whose membership mask has that
// index set XORs the word in. The word with index data_count-1 closes the
// position and produces one output transaction carrying all six parity words
// (lanes at or above parity_count read zero); indexes at or above data_count
// are accepted and dropped. Sustained rate is one word per cycle while in_ready is
// high; a closing word passes through the queue into the output register. A
// four-entry queue sits between input and accumulators, so in_ready only drops
// once it fills behind a result held by out_ready low. Write configuration only when idle.
module xor_parity_erasure_encoder_core import xpe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [IDX_BITS-1:0]      block_index,
  input  logic [63:0]              data_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [OUT_BITS-1:0]      parity_word_0,
  output logic [OUT_BITS-1:0]      parity_word_1,
  output logic [OUT_BITS-1:0]      parity_word_2,
  output logic [OUT_BITS-1:0]      parity_word_3,
  output logic [OUT_BITS-1:0]      parity_word_4,
  output logic [OUT_BITS-1:0]      parity_word_5
);

  xpe_qstat_t          qstat;
  xpe_entry_t          push_entry;
  xpe_entry_t          head;
  logic                push;
  logic                pop;
  logic [OUT_BITS-1:0] parity_word [NUM_OUT];

  xpe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .block_index (block_index),
    .data_word   (data_word),
    .qstat       (qstat),
    .push        (push),
    .push_entry  (push_entry)
  );

  xpe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  xpe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .parity_word (parity_word)
  );

  assign parity_word_0 = parity_word[0];
  assign parity_word_1 = parity_word[1];
  assign parity_word_2 = parity_word[2];
  assign parity_word_3 = parity_word[3];
  assign parity_word_4 = parity_word[4];
  assign parity_word_5 = parity_word[5];

endmodule

// ----- tb/tb_xor_parity_erasure_encoder_core.sv -----
// Self-checking testbench for xor_parity_erasure_encoder_core: streams tagged data words under
// several register settings and checks every parity transaction against a scoreboard.
// Depends on xpe_pkg and the encoder RTL; reads no files.
module tb_xor_parity_erasure_encoder_core;
  timeunit 1ns;
  timeprecision 1ps;
  import xpe_pkg::*;

  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_WORDS   = 1850;

  typedef logic [NUM_OUT-1:0][OUT_BITS-1:0]    parity_set_t;
  typedef logic [NUM_MASKS-1:0][MASK_BITS-1:0] mask_set_t;

  // Scoreboard: mirrors the registers and lanes, queues the parity sets still owed
  class parity_scoreboard;
    logic [OUT_BITS-1:0]  lane_acc [NUM_OUT];
    logic [DC_BITS-1:0]   data_count;
    logic [PC_BITS-1:0]   parity_count;
    mask_set_t            masks;
    parity_set_t          expected_q[$];
    int                   mismatches;
    int                   results_checked;

    function new();
      foreach (lane_acc[j]) lane_acc[j] = '0;
      data_count      = 1;
      parity_count    = 1;
      masks           = '0;
      mismatches      = 0;
      results_checked = 0;
    endfunction

    function int eff_data();
      return (data_count > DATA_MAX) ? DATA_MAX : int'(data_count);
    endfunction

    function int eff_parity();
      int p;
      p = int'(parity_count);
      if (p > PARITY_MAX) p = PARITY_MAX;
      if (p > NUM_OUT) p = NUM_OUT;
      return p;
    endfunction

    function void write_reg(cfg_reg_t r, logic [CFG_DATA_BITS-1:0] v);
      case (r)
        REG_DATA_COUNT:   data_count = v[DC_BITS-1:0];
        REG_PARITY_COUNT: parity_count = v[PC_BITS-1:0];
        default:          masks[int'(r) - int'(REG_MASK_0)] = v[MASK_BITS-1:0];
      endcase
    endfunction

    // Fold one accepted word into the lanes; a closing index queues a parity set
    function void note_input(logic [IDX_BITS-1:0] idx, logic [63:0] w);
      int          k;
      int          m;
      parity_set_t p;
      k = eff_data();
      m = eff_parity();
      if (int'(idx) >= k) return;
      for (int j = 0; j < m; j++)
        if (masks[j][idx]) lane_acc[j] ^= w;
      if (int'(idx) + 1 != k) return;
      for (int j = 0; j < NUM_OUT; j++)
        p[j] = (j < m) ? lane_acc[j] : '0;
      expected_q.push_back(p);
      foreach (lane_acc[j]) lane_acc[j] = '0;
    endfunction

    function void check_result(parity_set_t got);
      parity_set_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: parity transaction %0d arrived with none owed, parity_word_0=%h",
                   results_checked, got[0]);
        return;
      end
      want = expected_q.pop_front();
      for (int j = 0; j < NUM_OUT; j++)
        if (got[j] !== want[j]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: transaction %0d parity_word_%0d expected %h actual %h",
                     results_checked, j, want[j], got[j]);
        end
    endfunction

    function void close_out();
      if (expected_q.size() != 0) begin
        mismatches += expected_q.size();
        $display("ERROR: %0d parity transactions never arrived", expected_q.size());
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = REG_DATA_COUNT;
  logic [CFG_DATA_BITS-1:0] cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [IDX_BITS-1:0]      block_index = '0;
  logic [63:0]              data_word = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [OUT_BITS-1:0]      parity_word_0, parity_word_1, parity_word_2;
  logic [OUT_BITS-1:0]      parity_word_3, parity_word_4, parity_word_5;

  parity_scoreboard sb = new();

  int  burst_left    = 0;
  bit  gaps_on       = 1'b1;
  int  live_words    = 0;
  int  dropped_words = 0;
  int  configs       = 0;
  int  stall_cycles  = 0;
  int  rx_cycle      = 0;
  int  rx_mode       = 0;
  int  rx_hold       = 0;

  xor_parity_erasure_encoder_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .block_index   (block_index),
    .data_word     (data_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .parity_word_0 (parity_word_0),
    .parity_word_1 (parity_word_1),
    .parity_word_2 (parity_word_2),
    .parity_word_3 (parity_word_3),
    .parity_word_4 (parity_word_4),
    .parity_word_5 (parity_word_5)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1)
      sb.check_result({parity_word_5, parity_word_4, parity_word_3,
                       parity_word_2, parity_word_1, parity_word_0});
  end

  // Receiver backpressure in four randomly chosen modes
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 80 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ((rx_cycle % 7) >= 3);
      default: begin
        if (rx_hold > 0) rx_hold--;
        else if ($urandom_range(0, 9) == 0) rx_hold = $urandom_range(4, 16);
        out_ready <= (rx_hold == 0);
      end
    endcase
  end

  // Watchdog: too long without any transaction or register write
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: watchdog expired after %0d idle cycles", stall_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [MASK_BITS-1:0] pick_mask();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return MASK_BITS'(1) << $urandom_range(0, MASK_BITS - 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'(1) << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Present one data word in bursts with random gaps, hold until accepted
  task automatic send_word(logic [IDX_BITS-1:0] idx, logic [63:0] w);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = !gaps_on ? 0 :
            ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    block_index <= idx;
    data_word   <= w;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    if (int'(idx) < sb.eff_data()) live_words++;
    else dropped_words++;
    sb.note_input(idx, w);
    burst_left--;
  endtask

  // Stop sending and let the pipeline drain before touching registers
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write every register, one per cycle, write enable held across the sequence
  task automatic write_config(logic [DC_BITS-1:0] dc, logic [PC_BITS-1:0] pc, mask_set_t m);
    cfg_reg_t                 r;
    logic [CFG_DATA_BITS-1:0] v;
    cfg_wr_en <= 1'b1;
    for (int i = int'(REG_DATA_COUNT); i <= int'(REG_MASK_5); i++) begin
      r = cfg_reg_t'(i);
      case (r)
        REG_DATA_COUNT:   v = CFG_DATA_BITS'(dc);
        REG_PARITY_COUNT: v = CFG_DATA_BITS'(pc);
        default:          v = CFG_DATA_BITS'(m[i - int'(REG_MASK_0)]);
      endcase
      cfg_index   <= r;
      cfg_wr_data <= v;
      @(posedge clk);
      sb.write_reg(r, v);
    end
    cfg_wr_en <= 1'b0;
    configs++;
  endtask

  initial begin
    mask_set_t         m;
    logic [DC_BITS-1:0] dc;
    logic [PC_BITS-1:0] pc;
    int                keff;
    int                target;
    int                base;
    int                pick;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: one data block, one lane, empty masks
    send_word(5'd0, '1);
    send_word(5'd31, 64'h0123_4567_89AB_CDEF);  // beyond data count, dropped
    settle();

    // Three blocks, parity count above the lane count, mixed memberships
    m[0] = '1;
    m[1] = 32'h0000_0005;
    m[2] = 32'h8000_0002;
    m[3] = '0;
    m[4] = '1;
    m[5] = 32'h0000_0004;
    write_config(6'd3, 3'd7, m);
    send_word(5'd0, '1);
    send_word(5'd1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(5'd5, 64'h0000_0000_0000_1234);  // out of range, dropped
    send_word(5'd2, 64'h5555_5555_5555_5555);
    // repeated and out-of-order indexes still fold in
    send_word(5'd1, 64'h0F0F_0F0F_0F0F_0F0F);
    send_word(5'd1, 64'h00FF_00FF_00FF_00FF);
    send_word(5'd0, 64'h8000_0000_0000_0001);
    send_word(5'd2, 64'hDEAD_BEEF_0BAD_F00D);
    settle();

    // Oversized data count saturates, no parity lanes
    write_config(6'd63, 3'd0, m);
    send_word(5'd31, '1);
    settle();

    // Full-width stripe where only the end blocks are members
    foreach (m[j]) m[j] = 32'h8000_0001;
    write_config(6'd32, 3'd6, m);
    send_word(5'd0, 64'hFFFF_0000_FFFF_0000);
    send_word(5'd31, '1);
    settle();

    // Zero data count: everything dropped
    write_config(6'd0, 3'd6, m);
    send_word(5'd0, '1);
    send_word(5'd31, '0);
    settle();

    // Random phases: mostly clean stripes, some stray or repeated indexes
    base = live_words + dropped_words;
    while (live_words + dropped_words - base < RANDOM_WORDS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) dc = '0;
      else if (pick == 1) dc = DC_BITS'($urandom_range(33, 63));
      else if (pick < 5) dc = DC_BITS'(DATA_MAX);
      else dc = DC_BITS'($urandom_range(1, 8));
      pc = PC_BITS'($urandom_range(0, 7));
      foreach (m[j]) m[j] = pick_mask();
      gaps_on = ($urandom_range(0, 3) != 0);
      write_config(dc, pc, m);
      keff = sb.eff_data();
      if (keff == 0) begin
        repeat (12) send_word(IDX_BITS'($urandom_range(0, 31)), pick_word());
      end else begin
        target = live_words + $urandom_range(60, 200);
        while (live_words < target) begin
          if ($urandom_range(0, 9) < 8) begin
            for (int i = 0; i < keff; i++) send_word(IDX_BITS'(i), pick_word());
          end else begin
            repeat ($urandom_range(1, 4))
              send_word(IDX_BITS'($urandom_range(0, 31)), pick_word());
          end
        end
      end
      settle();
    end

    sb.close_out();
    $display("Run covered %0d register settings, %0d member words and %0d dropped words,",
             configs, live_words, dropped_words);
    $display("with %0d parity transactions checked.", sb.results_checked);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
